/* design/rthlc_pkg.sv */
// rthlc_pkg: shared types and constants for the rgb to hue led code converter
// no dependencies; used by rthlc_front, rthlc_back and rgb_to_hue_led_code_core
`default_nettype none

package rthlc_pkg;

  localparam logic [7:0] BUTTON_LED_COUNT = 8'd58;
  localparam logic [7:0] LAST_LIGHT_ID    = 8'(57 + 25 + 16);
  localparam logic [7:0] HUE_LED_ID       = 8'd5;
  localparam logic [5:0] HUE_SCALE        = 6'd43;
  localparam logic [7:0] HUE_BASE_R       = 8'd0;
  localparam logic [7:0] HUE_BASE_G       = 8'd85;
  localparam logic [7:0] HUE_BASE_B       = 8'd171;
  localparam logic [7:0] CODE_GREY        = 8'hFF;
  localparam logic [7:0] CODE_BLACK       = 8'h00;
  localparam int         BRIGHT_LSB       = 27;
  localparam int         NUM_W            = 14;
  localparam int         QUO_W            = 6;

  typedef struct packed {
    logic [7:0]  led_id;
    logic [31:0] color_word;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       bank;
    logic [5:0] led_index;
    logic [7:0] led_byte;
  } out_item_t;

  // classified request as it leaves the front
  typedef struct packed {
    logic       accepted;
    logic       bank;
    logic [5:0] led_index;
    logic       use_hue;
    logic [1:0] low_bits;
    logic [7:0] raw_byte;
    logic       is_black;
    logic       is_grey;
    logic [7:0] base;
    logic       neg;
    logic [7:0] mag;
    logic [7:0] span;
  } work_t;

  typedef struct packed {
    work_t            w;
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  // one restoring division step against a pre-shifted divisor
  function automatic logic [NUM_W:0] div_bit(logic [NUM_W-1:0] rem,
                                             logic [NUM_W-1:0] dsh);
    logic ge;
    ge = (rem >= dsh);
    return {ge, ge ? rem - dsh : rem};
  endfunction

endpackage

`default_nettype wire

/* design/rgb_to_hue_led_code_core.sv */
// rgb_to_hue_led_code_core: top level of the colour word to led code converter
// depends on rthlc_pkg, rthlc_front, rthlc_back
//
//   channel   handshake        payload
//   request   push / full      item   (led_id, color_word)
//   result    empty / pop      result (accepted, bank, led_index, led_byte)
//
// one request per cycle sustained while pop keeps up with the results
// each request gives exactly one result, passing the front queue, scale stage,
// three division stages of two quotient bits each into the result queue
// full rises only when the two-entry front queue holds two requests
// a stalled pop freezes the division pipe once its last stage is held
// rst is synchronous and empties both queues and the pipe
`default_nettype none

module rgb_to_hue_led_code_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire rthlc_pkg::in_item_t   item,
  output logic                       empty,
  input  wire logic                  pop,
  output rthlc_pkg::out_item_t       result
);

  logic             take;
  logic             work_valid;
  rthlc_pkg::work_t work;

  rthlc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .take       (take),
    .work_valid (work_valid),
    .work       (work)
  );

  rthlc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (work_valid),
    .work       (work),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire

/* design/rthlc_front.sv */
// rthlc_front: accepts requests, classifies id and colour, holds a two-entry queue
// depends on rthlc_pkg
`default_nettype none

module rthlc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire rthlc_pkg::in_item_t item,
  input  wire logic              take,
  output logic                   work_valid,
  output rthlc_pkg::work_t       work
);

  logic [7:0] r, g, b, hi, lo, id;
  logic [4:0] bright;
  logic signed [8:0] diff;
  logic [8:0] diff_abs;
  rthlc_pkg::work_t cls;
  rthlc_pkg::work_t e0, e1;
  logic [1:0] cnt, cnt_next;
  logic push_fire, pop_fire;

  always_comb begin
    id     = item.led_id;
    r      = item.color_word[23:16];
    g      = item.color_word[15:8];
    b      = item.color_word[7:0];
    bright = item.color_word[rthlc_pkg::BRIGHT_LSB +: 5];
    hi     = (r > g) ? r : g;
    hi     = (b > hi) ? b : hi;
    lo     = (r < g) ? r : g;
    lo     = (b < lo) ? b : lo;

    cls          = '0;
    cls.span     = hi - lo;
    cls.is_grey  = (hi == lo);
    cls.is_black = (item.color_word == 32'd0);
    if (hi == r) begin
      cls.base = rthlc_pkg::HUE_BASE_R;
      diff     = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (hi == g) begin
      cls.base = rthlc_pkg::HUE_BASE_G;
      diff     = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      cls.base = rthlc_pkg::HUE_BASE_B;
      diff     = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    cls.neg  = diff[8];
    diff_abs = diff[8] ? 9'(-diff) : 9'(diff);
    cls.mag  = diff_abs[7:0];

    if (id <= rthlc_pkg::LAST_LIGHT_ID) begin
      cls.accepted = 1'b1;
      cls.bank     = (id >= rthlc_pkg::BUTTON_LED_COUNT);
      if (cls.bank) begin
        cls.led_index = 6'(id - rthlc_pkg::BUTTON_LED_COUNT);
        cls.use_hue   = 1'b1;
        cls.low_bits  = bright[1:0];
      end else begin
        cls.led_index = id[5:0];
        cls.use_hue   = (id == rthlc_pkg::HUE_LED_ID);
        cls.low_bits  = bright[3:2];
        cls.raw_byte  = {3'b000, bright};
      end
    end
  end

  assign full       = (cnt == 2'd2);
  assign push_fire  = push && !full;
  assign pop_fire   = take && (cnt != 2'd0);
  assign work_valid = (cnt != 2'd0);
  assign work       = e0;
  assign cnt_next   = cnt + {1'b0, push_fire} - {1'b0, pop_fire};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      if (cnt == 2'd2) begin
        e0 <= e1;
      end else begin
        e0 <= cls;
      end
      e1 <= cls;
    end else if (push_fire) begin
      if (cnt == 2'd0) begin
        e0 <= cls;
      end else begin
        e1 <= cls;
      end
    end
  end

endmodule

`default_nettype wire

/* design/rthlc_back.sv */
// rthlc_back: scale, pipelined hue division, code byte assembly and result queue
// depends on rthlc_pkg
`default_nettype none

module rthlc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              work_valid,
  input  wire rthlc_pkg::work_t  work,
  output logic                   take,
  output logic                   empty,
  input  wire logic              pop,
  output rthlc_pkg::out_item_t   result
);

  localparam int NW = rthlc_pkg::NUM_W;

  logic [4:1] v;
  rthlc_pkg::div_t s1, s2, s3, s4;
  rthlc_pkg::div_t n1, n2, n3, n4;
  logic [NW:0] a, c;
  logic [7:0] h, code;
  rthlc_pkg::out_item_t fin, o0, o1;
  logic [1:0] ocnt, ocnt_next;
  logic adv, opush, opop, ocan;

  // two quotient bits per stage, shifts 5..4, 3..2, 1..0
  always_comb begin
    n1     = '0;
    n1.w   = work;
    n1.rem = NW'(work.mag) * NW'(rthlc_pkg::HUE_SCALE);

    n2 = s1;
    a  = rthlc_pkg::div_bit(s1.rem, NW'({s1.w.span, 5'b0}));
    c  = rthlc_pkg::div_bit(a[NW-1:0], NW'({s1.w.span, 4'b0}));
    n2.rem      = c[NW-1:0];
    n2.quo[5:4] = {a[NW], c[NW]};

    n3 = s2;
    a  = rthlc_pkg::div_bit(s2.rem, NW'({s2.w.span, 3'b0}));
    c  = rthlc_pkg::div_bit(a[NW-1:0], NW'({s2.w.span, 2'b0}));
    n3.rem      = c[NW-1:0];
    n3.quo[3:2] = {a[NW], c[NW]};

    n4 = s3;
    a  = rthlc_pkg::div_bit(s3.rem, NW'({s3.w.span, 1'b0}));
    c  = rthlc_pkg::div_bit(a[NW-1:0], NW'(s3.w.span));
    n4.rem      = c[NW-1:0];
    n4.quo[1:0] = {a[NW], c[NW]};
  end

  always_comb begin
    if (s4.w.neg) begin
      h = s4.w.base - {2'b00, s4.quo};
    end else begin
      h = s4.w.base + {2'b00, s4.quo};
    end
    code = {4'b0000, h[7:4]} + 8'd1;
    if (s4.w.is_grey) begin
      code = rthlc_pkg::CODE_GREY;
    end
    if (s4.w.is_black) begin
      code = rthlc_pkg::CODE_BLACK;
    end
    fin.accepted  = s4.w.accepted;
    fin.bank      = s4.w.bank;
    fin.led_index = s4.w.led_index;
    fin.led_byte  = s4.w.use_hue ? {code[5:0], s4.w.low_bits} : s4.w.raw_byte;
  end

  assign opop      = pop && (ocnt != 2'd0);
  assign ocan      = (ocnt != 2'd2) || opop;
  assign adv       = !v[4] || ocan;
  assign opush     = v[4] && adv;
  assign take      = adv;
  assign empty     = (ocnt == 2'd0);
  assign result    = o0;
  assign ocnt_next = ocnt + {1'b0, opush} - {1'b0, opop};

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      ocnt <= 2'd0;
    end else begin
      ocnt <= ocnt_next;
      if (adv) begin
        v <= {v[3:1], work_valid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= n1;
      s2 <= n2;
      s3 <= n3;
      s4 <= n4;
    end
  end

  always_ff @(posedge clk) begin
    if (opop) begin
      if (ocnt == 2'd2) begin
        o0 <= o1;
      end else begin
        o0 <= fin;
      end
      o1 <= fin;
    end else if (opush) begin
      if (ocnt == 2'd0) begin
        o0 <= fin;
      end else begin
        o1 <= fin;
      end
    end
  end

endmodule

`default_nettype wire
